// ----- hw/rtl/dq_pkg.sv -----
// Shared types, codes and sizes of the double-ended queue.
package dq_pkg;

  // Default geometry of the ring store
  localparam int unsigned DQ_DEPTH      = 256;
  localparam int unsigned DQ_DATA_WIDTH = 32;

  // Fixed port field widths
  localparam int unsigned OP_W       = 3;
  localparam int unsigned VALUE_W    = 32;
  localparam int unsigned POS_W      = 9;
  localparam int unsigned DATA_OUT_W = 32;
  localparam int unsigned STATUS_W   = 2;
  localparam int unsigned LEN_W      = 9;

  // Command queue between front and back, and result queue
  localparam int unsigned CQ_DEPTH = 2;
  localparam int unsigned CQ_PTR_W = $clog2(CQ_DEPTH);
  localparam int unsigned CQ_CNT_W = $clog2(CQ_DEPTH + 1);
  localparam int unsigned OQ_DEPTH = 2;
  localparam int unsigned OQ_PTR_W = $clog2(OQ_DEPTH);
  localparam int unsigned OQ_CNT_W = $clog2(OQ_DEPTH + 1);

  // Operation codes on the input port
  typedef enum logic [OP_W-1:0] {
    OP_PUSH_LEFT  = 3'd0,
    OP_PUSH_RIGHT = 3'd1,
    OP_PULL_LEFT  = 3'd2,
    OP_PULL_RIGHT = 3'd3,
    OP_READ_POS   = 3'd4,
    OP_REVERSE    = 3'd5
  } op_e;

  // Result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_RANGE = 2'd3
  } status_e;

  // Decoded operation class
  typedef enum logic [2:0] {
    K_NOP,
    K_PUSH,
    K_PULL,
    K_READ,
    K_REV
  } kind_e;

  // Decoded command handed from front to back
  typedef struct packed {
    kind_e                    kind;
    logic                     right;
    logic [VALUE_W-1:0]       value;
    logic signed [POS_W-1:0]  position;
  } cmd_t;

endpackage

// ----- hw/rtl/dq_front.sv -----
// Front end: accepts items, decodes the operation and queues commands.
module dq_front import dq_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    push_i,
  output logic                    full_o,
  input  logic [OP_W-1:0]         operation_i,
  input  logic [VALUE_W-1:0]      value_i,
  input  logic signed [POS_W-1:0] position_i,
  output logic                    cmd_valid_o,
  output cmd_t                    cmd_o,
  input  logic                    cmd_pop_i
);

  cmd_t                cq_q [CQ_DEPTH];
  logic [CQ_PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [CQ_PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CQ_CNT_W-1:0] cnt_q, cnt_d;
  cmd_t                dec;
  logic                wr_en;
  logic                rd_en;

  // Classify the operation
  always_comb begin
    dec.value    = value_i;
    dec.position = position_i;
    dec.right    = 1'b0;
    dec.kind     = K_NOP;
    case (operation_i)
      OP_PUSH_LEFT, OP_PUSH_RIGHT: begin
        dec.kind  = K_PUSH;
        dec.right = (operation_i == OP_PUSH_RIGHT);
      end
      OP_PULL_LEFT, OP_PULL_RIGHT: begin
        dec.kind  = K_PULL;
        dec.right = (operation_i == OP_PULL_RIGHT);
      end
      OP_READ_POS: dec.kind = K_READ;
      OP_REVERSE:  dec.kind = K_REV;
      default:     dec.kind = K_NOP;
    endcase
  end

  assign full_o      = (cnt_q == CQ_CNT_W'(CQ_DEPTH));
  assign cmd_valid_o = (cnt_q != '0);
  assign cmd_o       = cq_q[rd_ptr_q];
  assign wr_en       = push_i && !full_o;
  assign rd_en       = cmd_pop_i && cmd_valid_o;

  // Queue pointers and fill count
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (wr_en) begin
      wr_ptr_d = (wr_ptr_q == CQ_PTR_W'(CQ_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (rd_en) begin
      rd_ptr_d = (rd_ptr_q == CQ_PTR_W'(CQ_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (wr_en && !rd_en) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!wr_en && rd_en) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Command storage
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      cq_q[wr_ptr_q] <= dec;
    end
  end

endmodule

// ----- hw/rtl/dq_back.sv -----
// Back end: ring store, end pointers, execution and result queue.
module dq_back import dq_pkg::*; #(
  parameter int unsigned DEPTH      = DQ_DEPTH,
  parameter int unsigned DATA_WIDTH = DQ_DATA_WIDTH
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cmd_valid_i,
  input  cmd_t                  cmd_i,
  output logic                  cmd_pop_o,
  input  logic                  res_pop_i,
  output logic                  res_empty_o,
  output logic [DATA_OUT_W-1:0] data_out_o,
  output logic [STATUS_W-1:0]   status_o,
  output logic [LEN_W-1:0]      length_o
);

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam int unsigned IW    = ((CNT_W > POS_W) ? CNT_W : POS_W) + 2;

  // Ring store
  logic [DATA_WIDTH-1:0] mem [DEPTH];
  logic [DATA_WIDTH-1:0] rd_q;

  // Deque state
  logic [PTR_W-1:0] lp_q, lp_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             rev_q, rev_d;

  // Store access of the issuing command
  logic                  issue;
  logic                  we, re, rd_sel;
  logic [PTR_W-1:0]      addr;
  logic [DATA_WIDTH-1:0] wdata;
  status_e               status;

  // Address arithmetic
  logic                  phys_right;
  logic [PTR_W-1:0]      off_sel;
  logic [PTR_W:0]        slot_sum;
  logic [PTR_W-1:0]      slot;
  logic [PTR_W-1:0]      lp_dec, lp_inc;
  logic [CNT_W-1:0]      cnt_m1;
  logic                  cnt_full;
  logic signed [IW-1:0]  pos_s, cnt_s, idx, off_s;
  logic                  rd_ok;

  // Result stage and result queue
  logic                  r_valid_q;
  logic                  r_rd_sel_q;
  status_e               r_status_q;
  logic [LEN_W-1:0]      r_len_q;
  logic [DATA_OUT_W-1:0] r_data;
  logic [DATA_OUT_W-1:0] oq_data_q   [OQ_DEPTH];
  status_e               oq_status_q [OQ_DEPTH];
  logic [LEN_W-1:0]      oq_len_q    [OQ_DEPTH];
  logic [OQ_PTR_W-1:0]   oq_wr_q, oq_rd_q;
  logic [OQ_CNT_W-1:0]   oq_cnt_q, oq_cnt_d;
  logic [OQ_CNT_W:0]     occ;
  logic                  res_acc;

  // Issue only when the result queue has room for everything in flight
  assign res_acc     = res_pop_i && !res_empty_o;
  assign occ         = (OQ_CNT_W + 1)'(oq_cnt_q) + (OQ_CNT_W + 1)'(r_valid_q)
                       - (OQ_CNT_W + 1)'(res_acc);
  assign issue       = cmd_valid_i && (occ < (OQ_CNT_W + 1)'(OQ_DEPTH));
  assign cmd_pop_o   = issue;

  // Ring slot of an offset from the left end, and end pointer steps
  assign phys_right = cmd_i.right ^ rev_q;
  assign slot_sum   = {1'b0, lp_q} + {1'b0, off_sel};
  assign slot       = (slot_sum >= (PTR_W + 1)'(DEPTH))
                      ? PTR_W'(slot_sum - (PTR_W + 1)'(DEPTH)) : slot_sum[PTR_W-1:0];
  assign lp_dec     = (lp_q == '0) ? PTR_W'(DEPTH - 1) : lp_q - 1'b1;
  assign lp_inc     = (lp_q == PTR_W'(DEPTH - 1)) ? '0 : lp_q + 1'b1;
  assign cnt_m1     = cnt_q - 1'b1;
  assign cnt_full   = (cnt_q == CNT_W'(DEPTH));

  // Signed position to logical index, then to offset from the left end
  assign pos_s = IW'(cmd_i.position);
  assign cnt_s = $signed(IW'(cnt_q));
  assign idx   = cmd_i.position[POS_W-1] ? cnt_s + pos_s : pos_s;
  assign rd_ok = !idx[IW-1] && (idx < cnt_s);
  assign off_s = rev_q ? cnt_s - idx - $signed(IW'(1)) : idx;

  // Offset from the left end for slot-addressed accesses
  always_comb begin
    off_sel = '0;
    case (cmd_i.kind)
      K_PUSH:  off_sel = cnt_q[PTR_W-1:0];
      K_PULL:  off_sel = cnt_m1[PTR_W-1:0];
      K_READ:  off_sel = off_s[PTR_W-1:0];
      default: off_sel = '0;
    endcase
  end

  // Execute one command
  always_comb begin
    lp_d    = lp_q;
    cnt_d   = cnt_q;
    rev_d   = rev_q;
    we      = 1'b0;
    re      = 1'b0;
    rd_sel  = 1'b0;
    addr    = slot;
    wdata   = DATA_WIDTH'(cmd_i.value);
    status  = ST_OK;
    case (cmd_i.kind)
      K_PUSH: begin
        if (cnt_full) begin
          status = ST_FULL;
        end else begin
          we    = 1'b1;
          cnt_d = cnt_q + 1'b1;
          if (phys_right) begin
            addr = slot;
          end else begin
            lp_d = lp_dec;
            addr = lp_dec;
          end
        end
      end
      K_PULL: begin
        if (cnt_q == '0) begin
          status = ST_EMPTY;
        end else begin
          re     = 1'b1;
          rd_sel = 1'b1;
          cnt_d  = cnt_m1;
          if (phys_right) begin
            addr = slot;
          end else begin
            addr = lp_q;
            lp_d = lp_inc;
          end
        end
      end
      K_READ: begin
        if (!rd_ok) begin
          status = ST_RANGE;
        end else begin
          re     = 1'b1;
          rd_sel = 1'b1;
          addr   = slot;
        end
      end
      K_REV:   rev_d = !rev_q;
      default: ;
    endcase
  end

  // Deque state and result stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lp_q       <= '0;
      cnt_q      <= '0;
      rev_q      <= 1'b0;
      r_valid_q  <= 1'b0;
      r_rd_sel_q <= 1'b0;
      r_status_q <= ST_OK;
      r_len_q    <= '0;
    end else begin
      r_valid_q <= issue;
      if (issue) begin
        lp_q       <= lp_d;
        cnt_q      <= cnt_d;
        rev_q      <= rev_d;
        r_rd_sel_q <= rd_sel;
        r_status_q <= status;
        r_len_q    <= LEN_W'(cnt_d);
      end
    end
  end

  // Store write and registered read
  always_ff @(posedge clk_i) begin
    if (issue && we) begin
      mem[addr] <= wdata;
    end
    if (issue && re) begin
      rd_q <= mem[addr];
    end
  end

  assign r_data = r_rd_sel_q ? DATA_OUT_W'(rd_q) : '0;

  // Result queue
  always_comb begin
    oq_cnt_d = oq_cnt_q;
    if (r_valid_q && !res_acc) begin
      oq_cnt_d = oq_cnt_q + 1'b1;
    end else if (!r_valid_q && res_acc) begin
      oq_cnt_d = oq_cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      oq_wr_q  <= '0;
      oq_rd_q  <= '0;
      oq_cnt_q <= '0;
    end else begin
      oq_cnt_q <= oq_cnt_d;
      if (r_valid_q) begin
        oq_wr_q <= (oq_wr_q == OQ_PTR_W'(OQ_DEPTH - 1)) ? '0 : oq_wr_q + 1'b1;
      end
      if (res_acc) begin
        oq_rd_q <= (oq_rd_q == OQ_PTR_W'(OQ_DEPTH - 1)) ? '0 : oq_rd_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (r_valid_q) begin
      oq_data_q[oq_wr_q]   <= r_data;
      oq_status_q[oq_wr_q] <= r_status_q;
      oq_len_q[oq_wr_q]    <= r_len_q;
    end
  end

  assign res_empty_o = (oq_cnt_q == '0);
  assign data_out_o  = oq_data_q[oq_rd_q];
  assign status_o    = oq_status_q[oq_rd_q];
  assign length_o    = oq_len_q[oq_rd_q];

endmodule

// ----- hw/rtl/double_ended_queue.sv -----
// Top level of the bounded double-ended queue.
//
// Input channel: present operation_i, value_i and position_i with push high;
// the item is taken at a clock edge where push is high and full is low.
// Result channel: while empty is low the oldest result sits on data_out_o,
// status_o and length_o; it is taken at an edge where pop is high.
// Every item gives exactly one result, in order.
// Path: an item passes the command queue, then execute with a registered
// store read, then the result queue. Throughput: one item per cycle
// sustained while pop takes the results; the single-port ring store with
// its registered read and the in-order pointer update set this figure.
// Reset: command and result queues empty, deque empty with normal
// orientation; the store contents are not cleared and are never shown
// before being written.
// Stall: if pop stays low, up to two results wait in the result queue, then
// execution halts, the two-entry command queue fills and full goes high.
module double_ended_queue import dq_pkg::*; #(
  parameter int unsigned DEPTH      = DQ_DEPTH,
  parameter int unsigned DATA_WIDTH = DQ_DATA_WIDTH
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    push,
  output logic                    full,
  input  logic [OP_W-1:0]         operation_i,
  input  logic [VALUE_W-1:0]      value_i,
  input  logic signed [POS_W-1:0] position_i,
  output logic                    empty,
  input  logic                    pop,
  output logic [DATA_OUT_W-1:0]   data_out_o,
  output logic [STATUS_W-1:0]     status_o,
  output logic [LEN_W-1:0]        length_o
);

  logic cmd_valid;
  logic cmd_pop;
  cmd_t cmd;

  dq_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .full_o      (full),
    .operation_i (operation_i),
    .value_i     (value_i),
    .position_i  (position_i),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd),
    .cmd_pop_i   (cmd_pop)
  );

  dq_back #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_pop_o   (cmd_pop),
    .res_pop_i   (pop),
    .res_empty_o (empty),
    .data_out_o  (data_out_o),
    .status_o    (status_o),
    .length_o    (length_o)
  );

endmodule

// ----- hw/rtl/dq_checker.sv -----
// Port-level checks of the double-ended queue, bound to the top level.
module dq_checker import dq_pkg::*; #(
  parameter int unsigned DEPTH = DQ_DEPTH
) (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  empty,
  input logic                  pop,
  input logic [DATA_OUT_W-1:0] data_out_o,
  input logic [STATUS_W-1:0]   status_o,
  input logic [LEN_W-1:0]      length_o
);

  logic [LEN_W-1:0] prev_len_q;
  logic             seen_q;

  // Length of the last item taken from the result side
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_len_q <= '0;
      seen_q     <= 1'b0;
    end else if (pop && !empty) begin
      prev_len_q <= length_o;
      seen_q     <= 1'b1;
    end
  end

  // Nothing waits on the result side once reset has been seen
  a_reset_empty: assert property (@(posedge clk_i) !rst_ni |=> empty)
    else $error("result waiting during reset");

  // Consecutive results differ in length by at most one entry
  a_len_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && seen_q) |-> ((length_o == prev_len_q) ||
                            (length_o == LEN_W'(prev_len_q + 1'b1)) ||
                            (prev_len_q == LEN_W'(length_o + 1'b1))))
    else $error("length jumped between results");

  // A refused push reports a full deque
  a_full_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && status_o == ST_FULL) |-> (length_o == LEN_W'(DEPTH) && data_out_o == '0))
    else $error("full status with wrong length or data");

  // A waiting result holds until taken
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(data_out_o) && $stable(status_o) &&
                          $stable(length_o)))
    else $error("waiting result changed");

endmodule

bind double_ended_queue dq_checker #(
  .DEPTH (DEPTH)
) u_dq_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .empty      (empty),
  .pop        (pop),
  .data_out_o (data_out_o),
  .status_o   (status_o),
  .length_o   (length_o)
);
